// ----- sv/rpa_pkg.sv -----
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared widths, codes, coefficient row type and sequencer states for the
// range progression add / range sum block.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int KIND_W = 2;
    localparam int POS_W  = 13;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 64;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [POS_W-1:0] LEN_RESET = 13'd4096;
    localparam logic [SUM_W-1:0] NEG_ONE   = '1;

    // Fenwick coefficients of prefix F(p) = a*T(p) + b*p + c, T(p) = p(p+1)/2
    typedef struct packed {
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] c;
    } coef_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CONST,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_PRE_RD,
        ST_PRE_ACC,
        ST_Q_RD,
        ST_Q_ACC,
        ST_EVAL,
        ST_DONE
    } state_t;

    function automatic coef_t coef_add(coef_t x, coef_t y);
        coef_t s;
        s.a = x.a + y.a;
        s.b = x.b + y.b;
        s.c = x.c + y.c;
        return s;
    endfunction

endpackage

// ----- sv/rpa_if.sv -----
// ----------------------------------------------------------------------------
// rpa_item_if / rpa_result_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface rpa_item_if;
    import rpa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [VAL_W-1:0]  value;
    logic [POS_W-1:0]         range_start;
    logic [POS_W-1:0]         range_end;

    modport source (output valid, kind, value, range_start, range_end, input ready);
    modport sink   (input valid, kind, value, range_start, range_end, output ready);
endinterface

interface rpa_result_if;
    import rpa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SUM_W-1:0]  range_sum;
    logic                     status;

    modport source (output valid, range_sum, status, input ready);
    modport sink   (input valid, range_sum, status, output ready);
endinterface

// ----- sv/rpa_ram.sv -----
// ----------------------------------------------------------------------------
// rpa_ram
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module rpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/range_progression_add_range_sum.sv -----
// ----------------------------------------------------------------------------
// range_progression_add_range_sum
// Progression add over a range and range sum over a signed array.
// ----------------------------------------------------------------------------
// Loaded elements live as running prefix sums in one RAM; progression adds live
// as three Fenwick coefficient columns (a, b, c) in a second RAM, one row per
// position, so the added amount up to p is a*p(p+1)/2 + b*p + c summed along
// the Fenwick path of p. Every item gives one result transaction. A load or a
// rejected item goes straight to the done state. An update computes its
// constants, then does a read-modify-write per Fenwick node on the paths from l
// and r+1. A query, for each of r and l-1, does a prefix read, a read per Fenwick
// node and a coefficient evaluation on a shared 32x32 multiplier.
// After reset the coefficient RAM is swept to zero, during which no item is
// taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module range_progression_add_range_sum #(
    parameter int MAX_ELEMENTS = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [rpa_pkg::POS_W-1:0]   cfg_wr_data,
    rpa_item_if.sink                    item,
    rpa_result_if.source                result
);
    import rpa_pkg::*;

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMENTS - 1);

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [POS_W-1:0]  len_reg;
    logic [POS_W-1:0]  load_count_reg, load_count_next;
    logic [SUM_W-1:0]  last_prefix_reg, last_prefix_next;
    logic [POS_W-1:0]  l_reg, l_next;
    logic [POS_W-1:0]  r_reg, r_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              pass_reg, pass_next;
    logic [2:0]        step_reg, step_next;
    coef_t             delta_reg, delta_next;
    coef_t             acc_reg, acc_next;
    logic [SUM_W-1:0]  prod_reg, prod_next;
    logic [VAL_W-1:0]  tval_reg, tval_next;
    logic [SUM_W-1:0]  fval_reg, fval_next;
    logic [SUM_W-1:0]  t0_reg, t0_next;
    logic [SUM_W-1:0]  cl_reg, cl_next;
    logic [SUM_W-1:0]  cr_reg, cr_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              status_reg, status_next;
    logic              pre_zero_reg, pre_zero_next;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  out_sum_reg;
    logic              out_status_reg;

    logic [POS_W-1:0]  len_eff;
    logic              range_ok, load_full, bad, accept, out_free;
    logic [POS_W-1:0]  m_pos, p_cur, p_clamp;
    logic              idx_over, idx_zero;
    logic [CW-1:0]     lowbit;
    logic [VAL_W-1:0]  mul_a, mul_b;
    logic [SUM_W-1:0]  fval_fin, value_ext;

    logic              coef_rd_en, coef_wr_en;
    logic [AW-1:0]     coef_rd_addr, coef_wr_addr;
    coef_t             coef_rd_data, coef_wr_data;
    logic              pre_rd_en, pre_wr_en;
    logic [AW-1:0]     pre_rd_addr, pre_wr_addr;
    logic [SUM_W-1:0]  pre_rd_data, pre_wr_data;

    rpa_ram #(.WIDTH($bits(coef_t)), .DEPTH(MAX_ELEMENTS)) u_coef_ram (
        .clk     (clk),
        .rd_en   (coef_rd_en),
        .rd_addr (coef_rd_addr),
        .rd_data (coef_rd_data),
        .wr_en   (coef_wr_en),
        .wr_addr (coef_wr_addr),
        .wr_data (coef_wr_data)
    );

    rpa_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ELEMENTS)) u_prefix_ram (
        .clk     (clk),
        .rd_en   (pre_rd_en),
        .rd_addr (pre_rd_addr),
        .rd_data (pre_rd_data),
        .wr_en   (pre_wr_en),
        .wr_addr (pre_wr_addr),
        .wr_data (pre_wr_data)
    );

    assign len_eff   = (32'(len_reg) > 32'(MAX_ELEMENTS)) ? POS_W'(MAX_ELEMENTS) : len_reg;
    assign range_ok  = (item.range_start != '0) && (item.range_start <= item.range_end)
                       && (item.range_end <= len_eff);
    assign load_full = (load_count_reg >= len_eff);
    assign accept    = item.valid && item.ready;
    assign out_free  = !out_valid_reg || result.ready;
    assign m_pos     = l_reg - POS_W'(1);
    assign p_cur     = pass_reg ? m_pos : r_reg;
    assign p_clamp   = (p_cur > load_count_reg) ? load_count_reg : p_cur;
    assign idx_over  = (32'(idx_reg) > 32'(MAX_ELEMENTS));
    assign idx_zero  = (idx_reg == '0);
    assign lowbit    = idx_reg & (~idx_reg + CW'(1));
    assign fval_fin  = fval_reg + {prod_reg[31:0], 32'd0};
    assign value_ext = {{(SUM_W-VAL_W){item.value[VAL_W-1]}}, item.value};

    always_comb
    begin
        case (item.kind)
            KIND_LOAD:  bad = load_full;
            KIND_ADD:   bad = !range_ok;
            KIND_QUERY: bad = !range_ok;
            default:    bad = 1'b1;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (clr_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (bad || item.kind == KIND_LOAD)
                        state_next = ST_DONE;
                    else if (item.kind == KIND_ADD)
                        state_next = ST_CONST;
                    else
                        state_next = ST_PRE_RD;
                end
            end
            ST_CONST:   if (step_reg == 3'd4) state_next = ST_UPD_RD;
            ST_UPD_RD:
            begin
                if (!idx_over)
                    state_next = ST_UPD_WR;
                else if (pass_reg)
                    state_next = ST_DONE;
            end
            ST_UPD_WR:  state_next = ST_UPD_RD;
            ST_PRE_RD:  state_next = ST_PRE_ACC;
            ST_PRE_ACC: state_next = ST_Q_RD;
            ST_Q_RD:    state_next = idx_zero ? ST_EVAL : ST_Q_ACC;
            ST_Q_ACC:   state_next = ST_Q_RD;
            ST_EVAL:    if (step_reg == 3'd6) state_next = pass_reg ? ST_DONE : ST_PRE_RD;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs: handshake, memory ports, multiplier operands
    always_comb
    begin
        item.ready   = (state_reg == ST_IDLE);
        coef_rd_en   = ((state_reg == ST_UPD_RD) && !idx_over)
                       || ((state_reg == ST_Q_RD) && !idx_zero);
        coef_rd_addr = AW'(idx_reg - CW'(1));
        coef_wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_UPD_WR);
        coef_wr_addr = (state_reg == ST_CLEAR) ? clr_reg : AW'(idx_reg - CW'(1));
        coef_wr_data = (state_reg == ST_CLEAR) ? '0 : coef_add(coef_rd_data, delta_reg);
        pre_rd_en    = (state_reg == ST_PRE_RD) && (p_clamp != '0);
        pre_rd_addr  = AW'(p_clamp - POS_W'(1));
        pre_wr_en    = accept && (item.kind == KIND_LOAD) && !load_full;
        pre_wr_addr  = AW'(load_count_reg);
        pre_wr_data  = last_prefix_reg + value_ext;

        mul_a = 32'(p_cur);
        mul_b = 32'(p_cur) + 32'd1;
        if (state_reg == ST_CONST)
        begin
            case (step_reg)
                3'd0:    begin mul_a = 32'(m_pos); mul_b = 32'(m_pos);         end
                3'd1:    begin mul_a = 32'(m_pos); mul_b = 32'(m_pos) + 32'd1; end
                3'd2:    begin mul_a = 32'(r_reg); mul_b = 32'(r_reg) + 32'd1; end
                default: begin mul_a = 32'(m_pos); mul_b = 32'(r_reg);         end
            endcase
        end
        else if (state_reg == ST_EVAL)
        begin
            case (step_reg)
                3'd2:    begin mul_a = acc_reg.a[31:0];  mul_b = tval_reg;     end
                3'd3:    begin mul_a = acc_reg.a[63:32]; mul_b = tval_reg;     end
                3'd4:    begin mul_a = acc_reg.b[31:0];  mul_b = 32'(p_cur);   end
                3'd5:    begin mul_a = acc_reg.b[63:32]; mul_b = 32'(p_cur);   end
                default: begin mul_a = 32'(p_cur); mul_b = 32'(p_cur) + 32'd1; end
            endcase
        end
        prod_next = 64'(mul_a) * 64'(mul_b);
    end

    // datapath
    always_comb
    begin
        clr_next         = clr_reg;
        load_count_next  = load_count_reg;
        last_prefix_next = last_prefix_reg;
        l_next           = l_reg;
        r_next           = r_reg;
        idx_next         = idx_reg;
        pass_next        = pass_reg;
        step_next        = step_reg;
        delta_next       = delta_reg;
        acc_next         = acc_reg;
        tval_next        = tval_reg;
        fval_next        = fval_reg;
        t0_next          = t0_reg;
        cl_next          = cl_reg;
        cr_next          = cr_reg;
        sum_next         = sum_reg;
        status_next      = status_reg;
        pre_zero_next    = pre_zero_reg;
        case (state_reg)
            ST_CLEAR: clr_next = clr_reg + AW'(1);
            ST_IDLE:
            begin
                if (accept)
                begin
                    l_next      = item.range_start;
                    r_next      = item.range_end;
                    status_next = bad;
                    sum_next    = '0;
                    pass_next   = 1'b0;
                    step_next   = '0;
                    if (pre_wr_en)
                    begin
                        load_count_next  = load_count_reg + POS_W'(1);
                        last_prefix_next = pre_wr_data;
                    end
                end
            end
            ST_CONST:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd1:    t0_next = prod_reg;
                    3'd2:    cl_next = t0_reg - (prod_reg >> 1);
                    3'd3:    t0_next = prod_reg >> 1;
                    3'd4:
                    begin
                        cr_next      = t0_reg - prod_reg;
                        idx_next     = CW'(l_reg);
                        pass_next    = 1'b0;
                        delta_next.a = 64'd1;
                        delta_next.b = -64'(m_pos);
                        delta_next.c = cl_reg;
                    end
                    default: ;
                endcase
            end
            ST_UPD_RD:
            begin
                if (idx_over && !pass_reg)
                begin
                    idx_next     = CW'(r_reg) + CW'(1);
                    pass_next    = 1'b1;
                    delta_next.a = NEG_ONE;
                    delta_next.b = 64'(m_pos);
                    delta_next.c = cr_reg;
                end
            end
            ST_UPD_WR: idx_next = idx_reg + lowbit;
            ST_PRE_RD:
            begin
                acc_next      = '0;
                idx_next      = CW'(p_cur);
                pre_zero_next = (p_clamp == '0);
                step_next     = '0;
            end
            ST_PRE_ACC:
            begin
                if (!pre_zero_reg)
                    sum_next = pass_reg ? sum_reg - pre_rd_data : sum_reg + pre_rd_data;
            end
            ST_Q_ACC:
            begin
                acc_next = coef_add(acc_reg, coef_rd_data);
                idx_next = idx_reg - lowbit;
            end
            ST_EVAL:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0: fval_next = acc_reg.c;
                    3'd1: tval_next = VAL_W'(prod_reg >> 1);
                    3'd3: fval_next = fval_reg + prod_reg;
                    3'd4: fval_next = fval_reg + {prod_reg[31:0], 32'd0};
                    3'd5: fval_next = fval_reg + prod_reg;
                    3'd6:
                    begin
                        sum_next  = pass_reg ? sum_reg - fval_fin : sum_reg + fval_fin;
                        pass_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            len_reg        <= LEN_RESET;
            load_count_reg <= '0;
            last_prefix_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            load_count_reg  <= load_count_next;
            last_prefix_reg <= last_prefix_next;
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg        <= l_next;
        r_reg        <= r_next;
        idx_reg      <= idx_next;
        pass_reg     <= pass_next;
        step_reg     <= step_next;
        delta_reg    <= delta_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        tval_reg     <= tval_next;
        fval_reg     <= fval_next;
        t0_reg       <= t0_next;
        cl_reg       <= cl_next;
        cr_reg       <= cr_next;
        sum_reg      <= sum_next;
        status_reg   <= status_next;
        pre_zero_reg <= pre_zero_next;
        if (state_reg == ST_DONE && out_free)
        begin
            out_sum_reg    <= sum_reg;
            out_status_reg <= status_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.range_sum = out_sum_reg;
    assign result.status    = out_status_reg;

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status |-> result.range_sum == '0)
        else $error("rejected transaction carries a nonzero sum");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !$past(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    a_upd_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD_WR |-> !idx_zero && !idx_over)
        else $error("coefficient write outside the array");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pre_wr_en |=> 32'(load_count_reg) <= 32'(MAX_ELEMENTS))
        else $error("load count beyond array size");

endmodule
